FILE: sv/slc_pkg.sv
// shared constants and types for the set-associative lru cache model
`timescale 1ns / 1ps
package slc_pkg;

  // defaults for the top level parameters
  localparam int MAX_SET_BITS_DEF = 8;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;

  // fixed field widths
  localparam int ADDR_BITS   = 64;
  localparam int ACT_W       = 2;
  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 6;
  localparam int SET_CFG_W   = 4;
  localparam int OFF_CFG_W   = 6;
  localparam int WAYS_CFG_W  = 4;
  localparam int OUT_FIELD_W = 2 + 3 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // access kinds
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STORE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

  // register reset values
  localparam logic [SET_CFG_W-1:0]  SET_BITS_RST = 4'd4;
  localparam logic [OFF_CFG_W-1:0]  OFF_BITS_RST = 6'd4;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RST     = 4'd1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // latch request fields and read the set row
    logic update;  // write back the row and load the result
  } slc_cmd_t;

endpackage

FILE: sv/slc_ctrl.sv
// controller state machine: request acceptance, row update and result handshake
`timescale 1ns / 1ps
module slc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output slc_pkg::slc_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept = (state_r == ST_IDLE) && in_tvalid;
    cmd.update = (state_r == ST_LOOK) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd.accept) state_nxt = ST_LOOK;
      ST_LOOK: if (cmd.update) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

FILE: sv/slc_dp.sv
// datapath: config registers, tag and rank row memories, lookup, lru update, totals
`timescale 1ns / 1ps
module slc_dp #(
  parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = slc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  slc_pkg::slc_cmd_t                cmd,
  input  logic [slc_pkg::ACT_W-1:0]        in_action,
  input  logic [slc_pkg::ADDR_BITS-1:0]    in_address,
  input  logic                             cfg_we,
  input  logic [slc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slc_pkg::CFG_W-1:0]        cfg_wdata,
  output logic [slc_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int SET_W     = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS;
  localparam int NUM_SETS  = 1 << SET_W;
  localparam int RANK_W    = (MAX_WAYS <= 2) ? 1 : $clog2(MAX_WAYS);
  localparam int META_W    = RANK_W + 1;
  localparam int LIM_W     = RANK_W + 1;
  localparam int WAY_IDX_W = (MAX_WAYS <= 2) ? 1 : $clog2(MAX_WAYS);
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int SHIFT_W   = 7;
  localparam int PAD_W     = slc_pkg::OUT_TDATA_W - slc_pkg::OUT_FIELD_W;

  function automatic logic [slc_pkg::CNT_W-1:0] sat_inc(input logic [slc_pkg::CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + slc_pkg::CNT_W'(1);
  endfunction

  // configuration registers
  logic [slc_pkg::SET_CFG_W-1:0]  set_bits_r;
  logic [slc_pkg::OFF_CFG_W-1:0]  off_bits_r;
  logic [slc_pkg::WAYS_CFG_W-1:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= slc_pkg::SET_BITS_RST;
      off_bits_r <= slc_pkg::OFF_BITS_RST;
      ways_r     <= slc_pkg::WAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slc_pkg::CFG_SET_BITS:    set_bits_r <= cfg_wdata[slc_pkg::SET_CFG_W-1:0];
        slc_pkg::CFG_OFFSET_BITS: off_bits_r <= cfg_wdata[slc_pkg::OFF_CFG_W-1:0];
        slc_pkg::CFG_WAYS:        ways_r     <= cfg_wdata[slc_pkg::WAYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective set bit and way counts
  logic [slc_pkg::SET_CFG_W-1:0] sbits;
  logic [WAY_CNT_W-1:0]          ways_eff;

  always_comb begin
    sbits = (32'(set_bits_r) > MAX_SET_BITS) ? slc_pkg::SET_CFG_W'(MAX_SET_BITS) : set_bits_r;
    priority if (ways_r == '0) begin
      ways_eff = WAY_CNT_W'(1);
    end else if (32'(ways_r) > MAX_WAYS) begin
      ways_eff = WAY_CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WAY_CNT_W'(ways_r);
    end
  end

  // address split
  logic [ADDR_WIDTH-1:0] addr, addr_sh, tag_in;
  logic [SET_W-1:0]      set_mask, set_idx;
  logic [SHIFT_W-1:0]    tag_shift;

  always_comb begin
    addr      = in_address[ADDR_WIDTH-1:0];
    addr_sh   = addr >> off_bits_r;
    set_mask  = ~({SET_W{1'b1}} << sbits);
    set_idx   = addr_sh[SET_W-1:0] & set_mask;
    tag_shift = SHIFT_W'(off_bits_r) + SHIFT_W'(sbits);
    tag_in    = addr >> tag_shift;
  end

  // request registers
  logic [ADDR_WIDTH-1:0]       tag_r;
  logic [SET_W-1:0]            set_r;
  logic [slc_pkg::ACT_W-1:0]   act_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_r <= tag_in;
      set_r <= set_idx;
      act_r <= in_action;
    end
  end

  // row memories, one row per set; row flags mark rows written since reset
  logic [MAX_WAYS*ADDR_WIDTH-1:0] tag_mem [NUM_SETS];
  logic [MAX_WAYS*META_W-1:0]     meta_mem [NUM_SETS];
  logic [NUM_SETS-1:0]            row_valid_r;
  logic [MAX_WAYS*ADDR_WIDTH-1:0] tag_rd_r, tag_wr;
  logic [MAX_WAYS*META_W-1:0]     meta_rd_r, meta_wr;
  logic                           rowv_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_rd_r  <= tag_mem[set_idx];
      meta_rd_r <= meta_mem[set_idx];
      rowv_rd_r <= row_valid_r[set_idx];
    end
    if (cmd.update) begin
      tag_mem[set_r]  <= tag_wr;
      meta_mem[set_r] <= meta_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (cmd.update) begin
      row_valid_r[set_r] <= 1'b1;
    end
  end

  // lookup and lru update
  logic [MAX_WAYS-1:0]  vld, in_use, hit_vec, inv_vec;
  logic [RANK_W-1:0]    rnk [MAX_WAYS];
  logic [WAY_IDX_W-1:0] hit_way, inv_way, vic_way, sel_way;
  logic                 hit, inv_found, evicted;
  logic [LIM_W-1:0]     limit;
  logic                 new_v;
  logic [RANK_W-1:0]    new_r;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      vld[i]     = rowv_rd_r & meta_rd_r[i*META_W + RANK_W];
      rnk[i]     = rowv_rd_r ? meta_rd_r[i*META_W +: RANK_W] : '0;
      in_use[i]  = 32'(ways_eff) > i;
      hit_vec[i] = in_use[i] && vld[i] && (tag_rd_r[i*ADDR_WIDTH +: ADDR_WIDTH] == tag_r);
      inv_vec[i] = in_use[i] && !vld[i];
    end
    hit       = |hit_vec;
    inv_found = |inv_vec;
    hit_way   = '0;
    inv_way   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_way = WAY_IDX_W'(i);
      if (inv_vec[i]) inv_way = WAY_IDX_W'(i);
    end
    // oldest way, lowest index wins ties
    vic_way = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && (rnk[i] > rnk[vic_way])) vic_way = WAY_IDX_W'(i);
    end
    evicted = !hit && !inv_found;
    sel_way = hit ? hit_way : (inv_found ? inv_way : vic_way);
    limit   = vld[sel_way] ? {1'b0, rnk[sel_way]} : LIM_W'(MAX_WAYS);

    meta_wr = meta_rd_r;
    for (int i = 0; i < MAX_WAYS; i++) begin
      new_v = vld[i];
      new_r = rnk[i];
      if (in_use[i]) begin
        if (32'(sel_way) == i) begin
          new_v = 1'b1;
          new_r = '0;
        end else if (vld[i] && ({1'b0, rnk[i]} < limit) && (32'(rnk[i]) < MAX_WAYS - 1)) begin
          new_r = rnk[i] + RANK_W'(1);
        end
      end
      meta_wr[i*META_W +: META_W] = {new_v, new_r};
    end

    tag_wr = tag_rd_r;
    tag_wr[sel_way*ADDR_WIDTH +: ADDR_WIDTH] = tag_r;
  end

  // running totals, which also serve as the held result
  logic [slc_pkg::CNT_W-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [slc_pkg::CNT_W-1:0] hit_once, hit_cnt_nxt;
  logic                      hit_flag_r, evict_flag_r;

  always_comb begin
    hit_once    = hit ? sat_inc(hit_cnt_r) : hit_cnt_r;
    // modify is a load then a store to the same line
    hit_cnt_nxt = (act_r == slc_pkg::ACT_MODIFY) ? sat_inc(hit_once) : hit_once;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (cmd.update) begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= hit ? miss_cnt_r : sat_inc(miss_cnt_r);
      evict_cnt_r <= evicted ? sat_inc(evict_cnt_r) : evict_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit_flag_r   <= hit;
      evict_flag_r <= evicted;
    end
  end

  assign out_tdata = {{PAD_W{1'b0}}, evict_cnt_r, miss_cnt_r, hit_cnt_r,
                      evict_flag_r, hit_flag_r};

endmodule

FILE: sv/set_assoc_lru_cache_sim_top.sv
// top level of the set-associative cache model with true lru replacement
`timescale 1ns / 1ps
// Usage:
//   in_*  : one access request per handshake; in_tuser carries the access kind
//           (load, store, modify), in_tdata the byte address.
//   out_* : one result per request: hit and eviction flags plus saturating
//           hit, miss and eviction totals after that request.
//   cfg_* : write port for set bit count, offset bit count and ways in use;
//           write only while no request is in flight.
// Timing: a request accepted at one edge reads its set row into registers; the update
//   then writes the updated tag and rank row back and loads the result, and
//   out_tvalid rises with that load. A new request is taken only after the
//   previous one's update, when the controller returns to idle.
// Stall: the result is held in the output register; a new request is still
//   accepted while it waits, but its update holds until the result is taken.
// Reset: rst_n clears the per-row flags, so all lines read as
//   invalid with rank zero, the totals clear and the registers return to
//   their defaults; requests are accepted right after reset.
module set_assoc_lru_cache_sim_top #(
  parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = slc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [slc_pkg::ADDR_BITS-1:0]    in_tdata,   // [63:0] address
  input  logic [slc_pkg::ACT_W-1:0]        in_tuser,   // [1:0] action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] was_hit, [1] was_eviction, [33:2] hit_total, [65:34] miss_total,
  // [97:66] eviction_total, [103:98] zero
  output logic [slc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic [slc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slc_pkg::CFG_W-1:0]        cfg_wdata
);

  slc_pkg::slc_cmd_t cmd;

  slc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  slc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_action  (in_tuser),
    .in_address (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tdata  (out_tdata)
  );

  // a request accepted leaves the block busy for its update cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one still in flight");

  // the update never overwrites a result that has not been taken
  a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!out_tvalid || out_tready))
    else $error("result overwritten before it was taken");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("hit and eviction reported together");

  // every new result follows an update command
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.update))
    else $error("result appeared without an update");

endmodule

FILE: tb/set_assoc_lru_cache_sim_top_tb.sv
// self-checking testbench for the set-associative lru cache model
`timescale 1ns / 1ps
module set_assoc_lru_cache_sim_top_tb;
  import slc_pkg::*;

  localparam int NWAYS       = MAX_WAYS_DEF;
  localparam int NSETBITS    = MAX_SET_BITS_DEF;
  localparam int NLINES      = (1 << NSETBITS) * NWAYS;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 4;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 45;
  localparam int DIR_ROWS    = 13;
  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic            hit;
    logic            evict;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evicts;
  } cache_result_t;

  typedef struct packed {
    logic [ACT_W-1:0]     kind;
    logic [ADDR_BITS-1:0] addr;
    logic                 typed;
    cache_result_t        want;
  } access_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [ADDR_BITS-1:0]   in_tdata;
  logic [ACT_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  // model of the cache contents and settings
  logic                 way_valid [NLINES];
  logic [ADDR_BITS-1:0] way_tag   [NLINES];
  logic [2:0]           way_age   [NLINES];
  logic [CNT_W-1:0]     hit_count, miss_count, evict_count;
  int                   sel_set_bits, sel_off_bits, sel_ways;

  cache_result_t pending_results [$];
  int            mismatches;
  int            quiet_cycles;
  int            send_idle_pct, recv_idle_pct;

  // sets 0, 1 and 15 at the default split, with wide addresses and the unknown kind
  access_row_t dir_rows [DIR_ROWS] = '{
    '{ACT_LOAD,    64'h0,                 1'b1, '{1'b0, 1'b0, 32'd0, 32'd1, 32'd0}},
    '{ACT_LOAD,    64'h0,                 1'b1, '{1'b1, 1'b0, 32'd1, 32'd1, 32'd0}},
    '{ACT_MODIFY,  64'h8,                 1'b1, '{1'b1, 1'b0, 32'd3, 32'd1, 32'd0}},
    '{ACT_STORE,   64'h100,               1'b1, '{1'b0, 1'b1, 32'd3, 32'd2, 32'd1}},
    '{ACT_UNKNOWN, 64'h100,               1'b1, '{1'b1, 1'b0, 32'd4, 32'd2, 32'd1}},
    '{ACT_LOAD,    64'hffff_ffff_ffff_ffff, 1'b1, '{1'b0, 1'b0, 32'd4, 32'd3, 32'd1}},
    '{ACT_MODIFY,  64'hffff_ffff_ffff_ffff, 1'b1, '{1'b1, 1'b0, 32'd6, 32'd3, 32'd1}},
    '{ACT_MODIFY,  64'h200,               1'b1, '{1'b0, 1'b1, 32'd7, 32'd4, 32'd2}},
    '{ACT_STORE,   64'h8000_0000_0000_0000, 1'b1, '{1'b0, 1'b1, 32'd7, 32'd5, 32'd3}},
    '{ACT_LOAD,    64'h10,                1'b1, '{1'b0, 1'b0, 32'd7, 32'd6, 32'd3}},
    '{ACT_STORE,   64'h5555_5555_5555_5555, 1'b0, '0},
    '{ACT_LOAD,    64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0},
    '{ACT_MODIFY,  64'h5555_5555_5555_5550, 1'b0, '0}
  };

  int phase_set  [PHASES] = '{2, 0, 8, 15, 8, 1, 2, 8, 4};
  int phase_off  [PHASES] = '{4, 0, 6, 63, 56, 48, 2, 0, 4};
  int phase_ways [PHASES] = '{4, 8, 2, 0, 12, 3, 8, 5, 1};

  set_assoc_lru_cache_sim_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // one access against the cache model: lookup, fill or evict, recency update
  function automatic cache_result_t predict_access(input logic [ACT_W-1:0] kind,
                                                   input logic [ADDR_BITS-1:0] addr);
    cache_result_t        res;
    int                   sb, nw, ob, base, w, limit, i;
    logic [ADDR_BITS-1:0] set_idx, tag;
    logic                 hit, evict, found;
    sb = (sel_set_bits > NSETBITS) ? NSETBITS : sel_set_bits;
    nw = (sel_ways == 0) ? 1 : ((sel_ways > NWAYS) ? NWAYS : sel_ways);
    ob = sel_off_bits;
    set_idx = (addr >> ob) & ((64'd1 << sb) - 1);
    tag = (ob + sb >= ADDR_BITS) ? '0 : (addr >> (ob + sb));
    base = int'(set_idx) * NWAYS;
    hit = 1'b0;
    evict = 1'b0;
    found = 1'b0;
    w = 0;
    for (i = 0; i < nw; i++) begin
      if (!hit && way_valid[base + i] && way_tag[base + i] == tag) begin
        hit = 1'b1;
        w = i;
      end
    end
    if (hit) begin
      hit_count = bump(hit_count);
    end else begin
      miss_count = bump(miss_count);
      for (i = 0; i < nw; i++) begin
        if (!found && !way_valid[base + i]) begin
          found = 1'b1;
          w = i;
        end
      end
      if (!found) begin
        // oldest way, lowest index on a tie
        w = 0;
        for (i = 1; i < nw; i++) begin
          if (way_age[base + i] > way_age[base + w]) w = i;
        end
        evict = 1'b1;
        evict_count = bump(evict_count);
      end
    end
    limit = way_valid[base + w] ? int'(way_age[base + w]) : NWAYS;
    for (i = 0; i < nw; i++) begin
      if (i != w && way_valid[base + i] && way_age[base + i] < limit &&
          way_age[base + i] < NWAYS - 1) begin
        way_age[base + i] = way_age[base + i] + 1'b1;
      end
    end
    way_age[base + w] = '0;
    way_valid[base + w] = 1'b1;
    way_tag[base + w] = tag;
    if (kind == ACT_MODIFY) hit_count = bump(hit_count);
    res.hit = hit;
    res.evict = evict;
    res.hits = hit_count;
    res.misses = miss_count;
    res.evicts = evict_count;
    return res;
  endfunction

  task automatic send_access(input logic [ACT_W-1:0] kind, input logic [ADDR_BITS-1:0] addr,
                             input logic typed, input cache_result_t want);
    cache_result_t model;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model = predict_access(kind, addr);
    pending_results.push_back(typed ? want : model);
  endtask

  // back-to-back register writes, enable lowered once at the end
  task automatic write_settings(input int set_bits, input int off_bits, input int ways);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SET_BITS;
    cfg_wdata <= CFG_W'(set_bits);
    @(posedge clk);
    cfg_index <= CFG_OFFSET_BITS;
    cfg_wdata <= CFG_W'(off_bits);
    @(posedge clk);
    cfg_index <= CFG_WAYS;
    cfg_wdata <= CFG_W'(ways);
    @(posedge clk);
    cfg_we <= 1'b0;
    sel_set_bits = set_bits & 4'hf;
    sel_off_bits = off_bits & 6'h3f;
    sel_ways     = ways & 4'hf;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic note_field(input string field, input logic [CNT_W-1:0] want,
                            input logic [CNT_W-1:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t: %s expected %h got %h", $realtime, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    cache_result_t want;
    cache_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit    = out_tdata[0];
      got.evict  = out_tdata[1];
      got.hits   = out_tdata[33:2];
      got.misses = out_tdata[65:34];
      got.evicts = out_tdata[97:66];
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("%0t: result with no request pending", $realtime);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        note_field("was_hit", CNT_W'(want.hit), CNT_W'(got.hit));
        note_field("was_eviction", CNT_W'(want.evict), CNT_W'(got.evict));
        note_field("hit_total", want.hits, got.hits);
        note_field("miss_total", want.misses, got.misses);
        note_field("eviction_total", want.evicts, got.evicts);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("set_assoc_lru_cache_sim_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int                   r, p, n;
    logic [ADDR_BITS-1:0] addr, tag_base;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= ACT_LOAD;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_SET_BITS;
    cfg_wdata  <= '0;
    quiet_cycles = 0;
    mismatches = 0;
    send_idle_pct = 23;
    recv_idle_pct = 63;
    for (r = 0; r < NLINES; r++) begin
      way_valid[r] = 1'b0;
      way_tag[r]   = '0;
      way_age[r]   = '0;
    end
    hit_count = '0;
    miss_count = '0;
    evict_count = '0;
    sel_set_bits = SET_BITS_RST;
    sel_off_bits = OFF_BITS_RST;
    sel_ways     = WAYS_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < DIR_ROWS; r++)
      send_access(dir_rows[r].kind, dir_rows[r].addr, dir_rows[r].typed, dir_rows[r].want);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      write_settings(phase_set[p], phase_off[p], phase_ways[p]);
      if (p < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 63;
      end else if (p < 6) begin
        send_idle_pct = 63;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      tag_base = {$urandom, $urandom};
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // mostly a small pool of tags and sets so lines hit, age and get evicted
        if ($urandom_range(0, 9) < 8) begin
          addr = ((tag_base ^ 64'($urandom_range(0, phase_ways[p] + 2)))
                   << (phase_off[p] + phase_set[p]))
               | ((64'($urandom_range(0, 3)) & ((64'd1 << phase_set[p]) - 1))
                   << phase_off[p])
               | ({$urandom, $urandom} & ((64'd1 << phase_off[p]) - 1));
        end else begin
          addr = {$urandom, $urandom};
        end
        send_access(ACT_W'($urandom_range(0, 3)), addr, 1'b0, '0);
      end
    end
    drain_results();

    if (mismatches == 0) begin
      $display("set_assoc_lru_cache_sim_top: match");
    end else begin
      $display("set_assoc_lru_cache_sim_top: mismatch");
    end
    $finish;
  end

endmodule
